// ===== sv/bcc_pkg.sv =====
// Package for the block content classifier: payload structs, field codes,
// load thresholds and count widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bcc_pkg;

  localparam int SAMPLE_LIMIT = 4096;
  localparam int CNT_W        = $clog2(SAMPLE_LIMIT + 1);
  localparam int PROD_W       = CNT_W + 3;

  localparam int LOAD_W = 12;
  localparam int LEVEL_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  // Load thresholds, 8 fraction bits.
  localparam logic signed [LOAD_W-1:0] LOAD_HIGH   = 12'sd384;
  localparam logic signed [LOAD_W-1:0] LOAD_RAISED = 12'sd307;
  localparam logic signed [LOAD_W-1:0] LOAD_ONE    = 12'sd256;
  localparam logic signed [LOAD_W-1:0] LOAD_LOW    = 12'sd128;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 4'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd9;
  localparam logic [LEVEL_W-1:0] BASE_LEVEL_RESET = 4'd6;

  typedef enum logic [1:0] {
    TYPE_COMPRESSED = 2'd0,
    TYPE_TEXT       = 2'd1,
    TYPE_BINARY     = 2'd2
  } content_type_t;

  typedef enum logic [1:0] {
    ALGO_NONE  = 2'd0,
    ALGO_LZ4   = 2'd1,
    ALGO_ZSTD  = 2'd2,
    ALGO_OTHER = 2'd3
  } algorithm_t;

  localparam logic [CFG_INDEX_W-1:0] REG_PREFERRED_ALGORITHM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEVEL          = 2'd1;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     end_of_block;
    logic signed [LOAD_W-1:0] system_load;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         content_type;
    logic [1:0]         chosen_algorithm;
    logic [LEVEL_W-1:0] chosen_level;
  } out_item_t;

  function automatic logic is_printable(input logic [7:0] c);
    return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c >= 8'h20 && c <= 8'h7E);
  endfunction

endpackage
`default_nettype wire

// ===== sv/block_content_classifier.sv =====
// Block content classifier top level: byte counters, head capture, and the
// registered classification result. Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one byte per cycle and keeps the first four bytes and the
// sampled and printable counts of the first SAMPLE_LIMIT bytes. The result
// for a block is computed from those counters in the same cycle that the
// final byte is accepted and appears in the output register on the next
// cycle, so bytes flow at one per cycle. Ordinary bytes are never held back;
// only a final byte is stalled, and only while the previous result still
// sits unclaimed in the output register. Configuration writes take effect on
// the next cycle.
module block_content_classifier (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  bcc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output bcc_pkg::out_item_t           out_data
);
  import bcc_pkg::*;

  logic [1:0]         preferred_algorithm;
  logic [LEVEL_W-1:0] base_level;

  logic [7:0]       head_bytes [4];
  logic [CNT_W-1:0] sampled_count;
  logic [CNT_W-1:0] printable_count;

  logic [7:0]       head_next [4];
  logic [CNT_W-1:0] sampled_next;
  logic [CNT_W-1:0] printable_next;
  logic             in_accept;
  logic             packed_hit;
  logic             text_hit;
  logic [PROD_W-1:0] printable_x5;
  logic [PROD_W-1:0] sampled_x4;
  content_type_t    type_sel;
  algorithm_t       algo_sel;
  logic signed [5:0] level_adj;
  logic [LEVEL_W-1:0] level_sel;
  out_item_t        result;

  assign in_stall  = out_valid && out_stall && in_data.end_of_block;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      head_next[i] = head_bytes[i];
    end
    if (sampled_count < CNT_W'(4)) begin
      head_next[sampled_count[1:0]] = in_data.data_byte;
    end
    sampled_next   = sampled_count;
    printable_next = printable_count;
    if (sampled_count < CNT_W'(SAMPLE_LIMIT)) begin
      sampled_next = sampled_count + CNT_W'(1);
      if (is_printable(in_data.data_byte)) begin
        printable_next = printable_count + CNT_W'(1);
      end
    end
  end

  // A prefix only matches when the block is at least as long as the prefix.
  always_comb begin
    packed_hit =
      (sampled_next >= CNT_W'(2) && head_next[0] == 8'h1F && head_next[1] == 8'h8B) ||
      (sampled_next >= CNT_W'(2) && head_next[0] == 8'h78 && head_next[1] == 8'h9C) ||
      (sampled_next >= CNT_W'(4) && head_next[0] == 8'h50 && head_next[1] == 8'h4B &&
       head_next[2] == 8'h03 && head_next[3] == 8'h04) ||
      (sampled_next >= CNT_W'(4) && head_next[0] == 8'h28 && head_next[1] == 8'hB5 &&
       head_next[2] == 8'h2F && head_next[3] == 8'hFD) ||
      (sampled_next >= CNT_W'(4) && head_next[0] == 8'h04 && head_next[1] == 8'h22 &&
       head_next[2] == 8'h4D && head_next[3] == 8'h18);

    printable_x5 = PROD_W'({printable_next, 2'b00}) + PROD_W'(printable_next);
    sampled_x4   = PROD_W'({sampled_next, 2'b00});
    text_hit     = printable_x5 > sampled_x4;

    if (packed_hit) begin
      type_sel = TYPE_COMPRESSED;
    end else if (text_hit) begin
      type_sel = TYPE_TEXT;
    end else begin
      type_sel = TYPE_BINARY;
    end

    if (type_sel == TYPE_COMPRESSED) begin
      algo_sel = ALGO_NONE;
    end else begin
      algo_sel = (type_sel == TYPE_TEXT) ? ALGO_ZSTD : ALGO_LZ4;
      if (preferred_algorithm != ALGO_NONE) begin
        algo_sel = algorithm_t'(preferred_algorithm);
      end
      if (in_data.system_load > LOAD_HIGH) begin
        algo_sel = ALGO_NONE;
      end else if (in_data.system_load > LOAD_RAISED && algo_sel == ALGO_ZSTD) begin
        algo_sel = ALGO_LZ4;
      end
    end

    // A negative load means unknown and leaves the level alone.
    level_adj = $signed({2'b00, base_level});
    if (!in_data.system_load[LOAD_W-1]) begin
      if (in_data.system_load > LOAD_HIGH) begin
        level_adj = level_adj - 6'sd3;
      end else if (in_data.system_load > LOAD_ONE) begin
        level_adj = level_adj - 6'sd2;
      end else if (in_data.system_load < LOAD_LOW) begin
        level_adj = level_adj + 6'sd1;
      end
    end
    if (level_adj < $signed({2'b00, LEVEL_MIN})) begin
      level_sel = LEVEL_MIN;
    end else if (level_adj > $signed({2'b00, LEVEL_MAX})) begin
      level_sel = LEVEL_MAX;
    end else begin
      level_sel = level_adj[LEVEL_W-1:0];
    end

    result.content_type     = type_sel;
    result.chosen_algorithm = algo_sel;
    result.chosen_level     = level_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preferred_algorithm <= ALGO_NONE;
      base_level          <= BASE_LEVEL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PREFERRED_ALGORITHM: preferred_algorithm <= cfg_data[1:0];
        REG_BASE_LEVEL:          base_level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        head_bytes[i] <= 8'h00;
      end
      sampled_count   <= '0;
      printable_count <= '0;
    end else if (in_accept) begin
      // The final byte of a block returns the counters to their cleared state.
      for (int i = 0; i < 4; i++) begin
        head_bytes[i] <= in_data.end_of_block ? 8'h00 : head_next[i];
      end
      sampled_count   <= in_data.end_of_block ? '0 : sampled_next;
      printable_count <= in_data.end_of_block ? '0 : printable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && in_data.end_of_block) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.end_of_block) begin
      out_data <= result;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.end_of_block |=> out_valid)
    else $error("final byte accepted without a result transaction");

  a_counters_cleared: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.end_of_block |=> sampled_count == '0 && printable_count == '0)
    else $error("block counters not cleared after final byte");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.chosen_level >= LEVEL_MIN && out_data.chosen_level <= LEVEL_MAX)
    else $error("chosen level outside 1..9");

  a_compressed_no_algo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.content_type == TYPE_COMPRESSED |->
      out_data.chosen_algorithm == ALGO_NONE)
    else $error("compressed block given an algorithm");

endmodule
`default_nettype wire

// ===== bench/block_content_classifier_tb.sv =====
// Self-checking testbench for block_content_classifier: streams directed and random
// data blocks, predicts each block's type, algorithm and level, and checks the results.
// Depends on bcc_pkg and the block_content_classifier RTL.
`timescale 1ns / 1ps

module block_content_classifier_tb;
  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 225;
  localparam int REPORT_MAX  = 10;

  // Load thresholds in fixed point with 8 fraction bits.
  localparam int LOAD_OVERLOAD = 384;
  localparam int LOAD_BUSY     = 307;
  localparam int LOAD_FULL     = 256;
  localparam int LOAD_QUIET    = 128;
  localparam int LOAD_MARKS[14] = '{127, 128, 129, 255, 256, 257, 306, 307, 308,
                                   383, 384, 385, 0, -1};

  localparam logic [15:0] SIG_GZIP = 16'h1F8B;
  localparam logic [15:0] SIG_ZLIB = 16'h789C;
  localparam logic [31:0] SIG_ZIP  = 32'h504B0304;
  localparam logic [31:0] SIG_ZSTD = 32'h28B52FFD;
  localparam logic [31:0] SIG_LZ4  = 32'h04224D18;

  // Indexes past the register list; writes there must have no effect.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam algorithm_t ALGO_PLAN[6] = '{ALGO_NONE, ALGO_OTHER, ALGO_LZ4, ALGO_ZSTD,
                                          ALGO_NONE, ALGO_OTHER};
  localparam logic [3:0] LEVEL_PLAN[6] = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd10, 4'd7};

  localparam int MAGIC_NONE   = 0;
  localparam int MAGIC_INTACT = 1;
  localparam int MAGIC_BROKEN = 2;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;

  // Configuration and per-block state as the classifier should hold them.
  algorithm_t cfg_algo = ALGO_NONE;
  logic [3:0] cfg_level = 4'd6;
  logic [7:0] head_seen[4] = '{default: 8'h00};
  int         n_sampled = 0;
  int         n_text = 0;

  in_item_t   byte_backlog[$];
  out_item_t  verdicts_due[$];
  int         n_queued = 0;
  int         n_taken = 0;
  int         n_err = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_req = 0;
  int         cycle_count = 0;
  logic       in_took = 1'b0;

  block_content_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit byte_is_text(input logic [7:0] c);
    return c inside {8'h09, 8'h0A, 8'h0D, [8'h20:8'h7E]};
  endfunction

  task automatic classify_byte(input in_item_t it);
    bit            magic_hit;
    content_type_t kind;
    algorithm_t    algo;
    int            ld;
    int            lvl;
    logic [31:0]   head4;
    out_item_t     v;
    if (n_sampled < 4) head_seen[n_sampled] = it.data_byte;
    if (n_sampled < SAMPLE_LIMIT) begin
      n_sampled++;
      if (byte_is_text(it.data_byte)) n_text++;
    end
    if (it.end_of_block) begin
      head4 = {head_seen[0], head_seen[1], head_seen[2], head_seen[3]};
      // A prefix only counts when the block is at least as long as the prefix.
      magic_hit = (n_sampled >= 2 && (head4[31:16] == SIG_GZIP ||
                                      head4[31:16] == SIG_ZLIB)) ||
                  (n_sampled >= 4 && (head4 == SIG_ZIP || head4 == SIG_ZSTD ||
                                      head4 == SIG_LZ4));
      if (magic_hit) kind = TYPE_COMPRESSED;
      else if (n_text * 5 > n_sampled * 4) kind = TYPE_TEXT;
      else kind = TYPE_BINARY;

      ld = $signed(it.system_load);
      if (kind == TYPE_COMPRESSED) begin
        algo = ALGO_NONE;
      end else begin
        algo = (kind == TYPE_TEXT) ? ALGO_ZSTD : ALGO_LZ4;
        if (cfg_algo != ALGO_NONE) algo = cfg_algo;
        if (ld > LOAD_OVERLOAD) algo = ALGO_NONE;
        else if (ld > LOAD_BUSY && algo == ALGO_ZSTD) algo = ALGO_LZ4;
      end

      // A negative load means unknown and leaves the level alone.
      lvl = cfg_level;
      if (ld >= 0) begin
        if (ld > LOAD_OVERLOAD) lvl -= 3;
        else if (ld > LOAD_FULL) lvl -= 2;
        else if (ld < LOAD_QUIET) lvl += 1;
      end
      if (lvl < 1) lvl = 1;
      if (lvl > 9) lvl = 9;

      v.content_type = kind;
      v.chosen_algorithm = algo;
      v.chosen_level = lvl[3:0];
      verdicts_due.push_back(v);
      head_seen = '{default: 8'h00};
      n_sampled = 0;
      n_text = 0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eob,
                           input logic signed [LOAD_W-1:0] ld);
    in_item_t it;
    it.data_byte = b;
    it.end_of_block = eob;
    it.system_load = ld;
    byte_backlog.push_back(it);
    n_queued++;
  endtask

  // Pushes a block of up to four bytes, taken from the top of bytes down.
  task automatic push_fixed(input int n, input logic [31:0] bytes, input int ld);
    int i;
    for (i = 0; i < n; i++) begin
      push_byte(bytes[31-8*i -: 8], i == n - 1,
                (i == n - 1) ? LOAD_W'(ld) : LOAD_W'($urandom));
    end
  endtask

  function automatic logic signed [LOAD_W-1:0] pick_load();
    int r;
    r = $urandom_range(9, 0);
    if (r < 4) return LOAD_W'(LOAD_MARKS[$urandom_range(13, 0)]);
    else if (r < 6) return LOAD_W'(0 - int'($urandom_range(2048, 1)));
    else if (r < 9) return LOAD_W'($urandom_range(600, 0));
    else return LOAD_W'($urandom);
  endfunction

  // A negative text_pct gives raw random bytes.
  function automatic logic [7:0] pick_byte(input int text_pct);
    logic [7:0] c;
    if (text_pct < 0) return 8'($urandom);
    if ($urandom_range(99, 0) < text_pct) begin
      case ($urandom_range(9, 0))
        0: return 8'h0A;
        1: return 8'h09;
        2: return 8'h0D;
        default: return 8'($urandom_range(8'h7E, 8'h20));
      endcase
    end
    do c = 8'($urandom); while (byte_is_text(c));
    return c;
  endfunction

  task automatic add_block(input int len, input int text_pct, input int magic_mode);
    logic [31:0] m;
    logic [7:0]  b;
    int          plen;
    int          flip;
    int          i;
    m = '0;
    plen = 0;
    if (magic_mode != MAGIC_NONE) begin
      case ($urandom_range(4, 0))
        0: begin m = {SIG_GZIP, 16'h0000}; plen = 2; end
        1: begin m = SIG_ZIP; plen = 4; end
        2: begin m = {SIG_ZLIB, 16'h0000}; plen = 2; end
        3: begin m = SIG_ZSTD; plen = 4; end
        default: begin m = SIG_LZ4; plen = 4; end
      endcase
      if (magic_mode == MAGIC_BROKEN) begin
        flip = $urandom_range(8 * plen - 1, 0);
        m[31-flip] = ~m[31-flip];
      end
    end
    for (i = 0; i < len; i++) begin
      if (i < plen) b = m[31-8*i -: 8];
      else if (i >= SAMPLE_LIMIT) b = pick_byte(0);
      else b = pick_byte(text_pct);
      push_byte(b, i == len - 1, (i == len - 1) ? pick_load() : LOAD_W'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_PREFERRED_ALGORITHM) cfg_algo = algorithm_t'(val[1:0]);
    else if (idx == REG_BASE_LEVEL) cfg_level = val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || verdicts_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Sender: a stalled transaction holds its payload until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (byte_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= byte_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      classify_byte(in_data);
      n_taken++;
    end
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_MAX)
          $display("unexpected result: type %0d algo %0d level %0d", out_data.content_type,
                   out_data.chosen_algorithm, out_data.chosen_level);
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.content_type !== want.content_type ||
            out_data.chosen_algorithm !== want.chosen_algorithm ||
            out_data.chosen_level !== want.chosen_level) begin
          n_err++;
          if (n_err <= REPORT_MAX)
            $display("result mismatch: expected type %0d algo %0d level %0d, got %0d %0d %0d",
                     want.content_type, want.chosen_algorithm, want.chosen_level,
                     out_data.content_type, out_data.chosen_algorithm, out_data.chosen_level);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int ph;
    int r;
    int len;
    int goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 68;

    // Directed blocks under the reset configuration: partial and complete magic
    // prefixes, a truncated prefix, text, binary, and loads around every threshold.
    push_fixed(1, 32'h1F000000, -2048);
    push_fixed(2, {SIG_GZIP, 16'h0000}, 2047);
    push_fixed(4, SIG_ZIP, 385);
    push_fixed(2, {SIG_ZLIB, 16'h0000}, 384);
    push_fixed(4, SIG_ZSTD, 308);
    push_fixed(3, SIG_LZ4, 307);
    push_fixed(3, 32'h48690A00, 257);
    push_fixed(2, 32'h00FF0000, 256);
    push_fixed(1, 32'h7E000000, 128);
    push_fixed(1, 32'h7F000000, 127);
    push_fixed(1, 32'h09000000, 0);
    push_fixed(1, 32'h0D000000, -1);

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_PREFERRED_ALGORITHM, {2'($urandom), ALGO_PLAN[ph]});
      write_reg(REG_BASE_LEVEL, LEVEL_PLAN[ph]);
      if (ph == 3) begin
        write_reg(REG_SPARE_2, 4'($urandom));
        write_reg(REG_SPARE_3, 4'($urandom));
      end
      @(posedge clk);
      send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 68 : 0;
      recv_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 31 : 0;
      // With the output held off, short blocks pile up until the input stalls.
      if (ph == 4) hold_req++;
      // Long blocks: one exactly fills the sample window, one runs past it.
      if (ph == 1) add_block(SAMPLE_LIMIT, 81, MAGIC_NONE);
      if (ph == 5) add_block(SAMPLE_LIMIT + $urandom_range(300, 50), 82, MAGIC_NONE);
      goal = n_queued + PHASE_ITEMS;
      while (n_queued < goal) begin
        r = $urandom_range(99, 0);
        len = (r < 60) ? $urandom_range(12, 1) :
              (r < 90) ? $urandom_range(40, 13) : $urandom_range(160, 41);
        r = $urandom_range(99, 0);
        if (r < 35) add_block(len, $urandom_range(1, 0) ? 85 : -1, MAGIC_INTACT);
        else if (r < 45) add_block(len, -1, MAGIC_BROKEN);
        else if (r < 65) add_block(len, 92, MAGIC_NONE);
        else if (r < 85) add_block(len, 80, MAGIC_NONE);
        else add_block(len, -1, MAGIC_NONE);
      end
    end

    wait_idle();
    repeat (5) @(negedge clk);
    if (n_err == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bcc_pkg.sv
sv/block_content_classifier.sv
bench/block_content_classifier_tb.sv
